// ===== rtl/core/otsu_pkg.sv =====
package otsu_pkg;

    localparam int BINS       = 256;
    localparam int MAX_PIXELS = 1048576;
    localparam int COUNT_W    = 21;
    localparam int COUNT_MAX  = (2 ** COUNT_W) - 1;
    localparam int PIX_CAP    = (MAX_PIXELS > COUNT_MAX) ? COUNT_MAX : MAX_PIXELS;
    localparam int IDX_W      = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int SPAN_W     = $clog2(BINS + 1) + 1;
    localparam int LVL_W      = 8;
    localparam int SUM_W      = COUNT_W + LVL_W;
    localparam int QUO_W      = LVL_W;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int PP_W       = COUNT_W + 2 * LVL_W;
    localparam int SCORE_W    = 2 * COUNT_W + 2 * LVL_W;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_CLASSIFY = 2'd1;
    localparam logic [1:0] OP_END      = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_THRESH = 1'b1;

    localparam logic REG_LOW  = 1'b0;
    localparam logic REG_HIGH = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_CLASSIFY,
        CMD_SWEEP
    } cmd_e;

    typedef struct packed {
        cmd_e             cmd;
        logic [LVL_W-1:0] pixel;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_SCAN_RD,
        ST_SCAN_LOAD,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_CMP,
        ST_EMIT
    } back_state_t;

endpackage

// ===== rtl/core/otsu_front.sv =====
module otsu_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [1:0]                  s_tuser,   // opcode
    input  logic [otsu_pkg::LVL_W-1:0]  s_tdata,   // pixel
    input  logic                        q_full,
    output logic                        push,
    output otsu_pkg::cmd_t              cmd
);
    import otsu_pkg::*;

    logic keep;

    always_comb begin
        keep      = 1'b1;
        cmd.pixel = s_tdata;
        cmd.cmd   = CMD_ADD;
        unique case (s_tuser)
            OP_ADD:      cmd.cmd = CMD_ADD;
            OP_CLASSIFY: cmd.cmd = CMD_CLASSIFY;
            OP_END:      cmd.cmd = CMD_SWEEP;
            OP_NONE:     keep = 1'b0;
            default:     keep = 1'b0;
        endcase
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready && keep;

endmodule

// ===== rtl/core/otsu_cmdq.sv =====
module otsu_cmdq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  otsu_pkg::cmd_t push_cmd,
    input  logic           pop,
    output otsu_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);
    import otsu_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/otsu_div.sv =====
module otsu_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [otsu_pkg::SUM_W-1:0]   dividend,
    input  logic [otsu_pkg::COUNT_W-1:0] divisor,
    output logic [otsu_pkg::QUO_W-1:0]   quotient,
    output logic                         done
);
    import otsu_pkg::*;

    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [SUM_W-1:0]  trial;
    logic              ge;

    assign trial    = SUM_W'(divisor) << step_reg;
    assign ge       = (rem_reg >= trial);
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_comb begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        active_next = active_reg;
        done_next   = done_reg;
        if (start) begin
            rem_next    = dividend;
            quo_next    = '0;
            step_next   = STEP_W'(QUO_W - 1);
            active_next = 1'b1;
            done_next   = 1'b0;
        end else if (active_reg) begin
            rem_next  = ge ? rem_reg - trial : rem_reg;
            quo_next  = {quo_reg[QUO_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

endmodule

// ===== rtl/core/otsu_back.sv =====
module otsu_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  otsu_pkg::cmd_t             head,
    input  logic                       q_empty,
    output logic                       pop,
    input  logic [otsu_pkg::LVL_W-1:0] low_level,
    input  logic [otsu_pkg::LVL_W-1:0] high_level,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic                       m_tuser,   // result_kind
    output logic [otsu_pkg::LVL_W-1:0] m_tdata    // value
);
    import otsu_pkg::*;

    back_state_t state_reg, state_next;

    logic [COUNT_W-1:0] mem [BINS];
    logic [BINS-1:0]    valid_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic [COUNT_W-1:0] hist_rd;

    logic [IDX_W-1:0]     addr_reg;
    logic [COUNT_W-1:0]   total_reg;
    logic [LVL_W-1:0]     thresh_reg;
    logic [SUM_W-1:0]     sum_high_reg, sum_low_reg;
    logic [COUNT_W-1:0]   n_low_reg, h_reg;
    logic [SCORE_W-1:0]   best_reg, score_reg;
    logic [IDX_W-1:0]     best_t_reg;
    logic [2*COUNT_W-1:0] nn_reg;
    logic [2*LVL_W-1:0]   dd_reg;
    logic [PP_W-1:0]      pp_lo_reg, pp_hi_reg;

    logic             m_tvalid_reg;
    logic             m_tuser_reg;
    logic [LVL_W-1:0] m_tdata_reg;

    logic [SPAN_W-1:0]  span_raw, span;
    logic [IDX_W-1:0]   last_idx;
    logic [LVL_W-1:0]   pix_off;
    logic [IDX_W-1:0]   add_idx;
    logic               below_cap;
    logic               at_last;
    logic [LVL_W-1:0]   lvl;
    logic [SUM_W-1:0]   lvl_h_rd, lvl_h_reg;
    logic [COUNT_W-1:0] n_high;
    logic               both_full;
    logic [QUO_W-1:0]   q_lo, q_hi, q_diff;
    logic               div_done_lo, div_done_hi;
    logic               out_free;

    logic mem_we, div_start, load_pix, load_thr, clear_hist;

    always_comb begin
        span_raw = (high_level > low_level) ?
                   SPAN_W'(high_level) - SPAN_W'(low_level) + 1'b1 : SPAN_W'(1);
        span     = (span_raw > SPAN_W'(BINS)) ? SPAN_W'(BINS) : span_raw;
        last_idx = IDX_W'(span - 1'b1);
        pix_off  = (head.pixel < low_level) ? '0 : head.pixel - low_level;
        add_idx  = (SPAN_W'(pix_off) > SPAN_W'(last_idx)) ? last_idx : IDX_W'(pix_off);
    end

    assign below_cap = (total_reg < COUNT_W'(PIX_CAP));
    assign at_last   = (addr_reg == last_idx);
    assign lvl       = LVL_W'(addr_reg) + low_level;
    assign hist_rd   = rd_vld_reg ? rd_data_reg : '0;
    assign lvl_h_rd  = SUM_W'(lvl) * SUM_W'(hist_rd);
    assign lvl_h_reg = SUM_W'(lvl) * SUM_W'(h_reg);
    assign n_high    = total_reg - n_low_reg;
    assign both_full = (n_low_reg != '0) && (n_high != '0);
    assign q_diff    = (q_lo > q_hi) ? q_lo - q_hi : q_hi - q_lo;
    assign out_free  = !m_tvalid_reg || m_tready;

    otsu_div u_div_lo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_low_reg),
        .divisor  (n_low_reg),
        .quotient (q_lo),
        .done     (div_done_lo)
    );

    otsu_div u_div_hi (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_high_reg),
        .divisor  (n_high),
        .quotient (q_hi),
        .done     (div_done_hi)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    unique case (head.cmd)
                        CMD_ADD:      state_next = below_cap ? ST_ADD_RD : ST_IDLE;
                        CMD_CLASSIFY: state_next = ST_IDLE;
                        CMD_SWEEP:    state_next = ST_SUM_RD;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RD:    state_next = ST_ADD_WR;
            ST_ADD_WR:    state_next = ST_IDLE;
            ST_SUM_RD:    state_next = ST_SUM_ACC;
            ST_SUM_ACC:   state_next = at_last ? ST_SCAN_RD : ST_SUM_RD;
            ST_SCAN_RD:   state_next = ST_SCAN_LOAD;
            ST_SCAN_LOAD: state_next = both_full ? ST_DIV : ST_CMP;
            ST_DIV:       state_next = (div_done_lo && div_done_hi) ? ST_MUL1 : ST_DIV;
            ST_MUL1:      state_next = ST_MUL2;
            ST_MUL2:      state_next = ST_MUL3;
            ST_MUL3:      state_next = ST_CMP;
            ST_CMP:       state_next = at_last ? ST_EMIT : ST_SCAN_RD;
            ST_EMIT:      state_next = out_free ? ST_IDLE : ST_EMIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pop        = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        load_pix   = 1'b0;
        load_thr   = 1'b0;
        clear_hist = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    if (head.cmd == CMD_CLASSIFY) begin
                        pop      = out_free;
                        load_pix = out_free;
                    end else begin
                        pop = 1'b1;
                    end
                end
            end
            ST_ADD_WR:    mem_we = 1'b1;
            ST_SCAN_LOAD: div_start = both_full;
            ST_EMIT: begin
                load_thr   = out_free;
                clear_hist = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            total_reg    <= '0;
            thresh_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clear_hist) begin
                valid_reg <= '0;
                total_reg <= '0;
            end else if (mem_we) begin
                valid_reg[addr_reg] <= 1'b1;
                total_reg           <= total_reg + 1'b1;
            end
            if (load_thr) begin
                thresh_reg <= LVL_W'(best_t_reg) + low_level;
            end
            if (load_pix || load_thr) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= hist_rd + 1'b1;
        end
        rd_data_reg <= mem[addr_reg];
        rd_vld_reg  <= valid_reg[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (load_pix) begin
            m_tuser_reg <= KIND_PIXEL;
            m_tdata_reg <= (head.pixel < thresh_reg) ? low_level : high_level;
        end else if (load_thr) begin
            m_tuser_reg <= KIND_THRESH;
            m_tdata_reg <= LVL_W'(best_t_reg) + low_level;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty && head.cmd == CMD_ADD) begin
                    addr_reg <= add_idx;
                end else begin
                    addr_reg     <= '0;
                    sum_high_reg <= '0;
                end
            end
            ST_SUM_ACC: begin
                sum_high_reg <= sum_high_reg + lvl_h_rd;
                if (at_last) begin
                    addr_reg    <= '0;
                    n_low_reg   <= '0;
                    sum_low_reg <= '0;
                    best_reg    <= '0;
                    best_t_reg  <= '0;
                end else begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end
            ST_SCAN_LOAD: begin
                h_reg     <= hist_rd;
                score_reg <= '0;
            end
            ST_MUL1: begin
                nn_reg <= (2*COUNT_W)'(n_low_reg) * (2*COUNT_W)'(n_high);
                dd_reg <= (2*LVL_W)'(q_diff) * (2*LVL_W)'(q_diff);
            end
            ST_MUL2: begin
                pp_lo_reg <= PP_W'(nn_reg[COUNT_W-1:0]) * PP_W'(dd_reg);
                pp_hi_reg <= PP_W'(nn_reg[2*COUNT_W-1:COUNT_W]) * PP_W'(dd_reg);
            end
            ST_MUL3: begin
                score_reg <= SCORE_W'(pp_lo_reg) + (SCORE_W'(pp_hi_reg) << COUNT_W);
            end
            ST_CMP: begin
                if (score_reg > best_reg) begin
                    best_reg   <= score_reg;
                    best_t_reg <= addr_reg;
                end
                n_low_reg    <= n_low_reg + h_reg;
                sum_low_reg  <= sum_low_reg + lvl_h_reg;
                sum_high_reg <= sum_high_reg - lvl_h_reg;
                if (!at_last) begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/otsu_threshold_binarizer.sv =====
// classify: one transaction per cycle when idle and the output is not stalled
// add pixel: one at a time through the histogram read state, then write state
// end of frame: a summing pass over the N bins in range, then a per-bin scan
// through the bit-serial mean dividers and the split score multiply
// reset: synchronous active-low aresetn, histogram cleared at once by valid bits
module otsu_threshold_binarizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // opcode
    input  logic [7:0]  s_tdata,   // pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // result_kind
    output logic [7:0]  m_tdata,   // value
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import otsu_pkg::*;

    logic [LVL_W-1:0] low_reg, high_reg;
    logic             cfg_wr;
    logic             q_full, q_empty, push, pop;
    cmd_t             push_cmd, head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HIGH) ? 32'(high_reg) : 32'(low_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LOW) begin
                low_reg <= pwdata[LVL_W-1:0];
            end else begin
                high_reg <= pwdata[LVL_W-1:0];
            end
        end
    end

    otsu_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    otsu_cmdq u_cmdq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    otsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .low_level  (low_reg),
        .high_level (high_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== rtl/core/otsu_checker.sv =====
module otsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic [7:0]  m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready |=>
            (paddr[2] != $past(paddr[2])) || (prdata == {24'd0, $past(pwdata[7:0])}))
        else $error("register readback mismatch");

endmodule

bind otsu_threshold_binarizer otsu_checker u_otsu_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import otsu_pkg::*;

    class otsu_scoreboard;
        logic [20:0] hist [256];
        logic [20:0] total;
        logic [7:0]  thr;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [8:0]  exp_q [$];
        int          errors;

        function new();
            for (int i = 0; i < 256; i++) hist[i] = '0;
            total = '0;
            thr = '0;
            lo = 8'd0;
            hi = 8'd255;
            errors = 0;
        endfunction

        function int span();
            int s;
            s = 1;
            if (hi > lo) s = hi - lo + 1;
            if (s > BINS) s = BINS;
            return s;
        endfunction

        function logic [7:0] otsu_level();
            int s;
            longint unsigned n_low, n_high, sum_low, sum_high, best, mu1, mu2, d, score;
            int best_t;
            s = span();
            n_low = 0;
            sum_low = 0;
            sum_high = 0;
            best = 0;
            best_t = 0;
            for (int t = 0; t < s; t++) sum_high += longint'(t + lo) * hist[t];
            for (int t = 0; t < s; t++) begin
                n_high = total - n_low;
                score = 0;
                if (n_low != 0 && n_high != 0) begin
                    mu1 = sum_low / n_low;
                    mu2 = sum_high / n_high;
                    d = (mu1 > mu2) ? mu1 - mu2 : mu2 - mu1;
                    score = n_low * n_high * d * d;
                end
                if (score > best) begin
                    best = score;
                    best_t = t;
                end
                n_low += hist[t];
                sum_low += longint'(t + lo) * hist[t];
                sum_high -= longint'(t + lo) * hist[t];
            end
            return 8'(best_t + lo);
        endfunction

        function void note_input(logic [1:0] op, logic [7:0] pix);
            int idx, s;
            logic [8:0] e;
            s = span();
            if (op == OP_ADD) begin
                if (total < PIX_CAP) begin
                    idx = (pix < lo) ? 0 : pix - lo;
                    if (idx > s - 1) idx = s - 1;
                    hist[idx]++;
                    total++;
                end
            end else if (op == OP_CLASSIFY) begin
                e = {KIND_PIXEL, (pix < thr) ? lo : hi};
                exp_q = {exp_q, e};
            end else if (op == OP_END) begin
                thr = otsu_level();
                for (int i = 0; i < 256; i++) hist[i] = '0;
                total = '0;
                e = {KIND_THRESH, thr};
                exp_q = {exp_q, e};
            end
        endfunction

        task check_result(logic kind, logic [7:0] val);
            logic [8:0] e;
            if (exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction kind=%0d value=%0d", kind, val));
                return;
            end
            e = exp_q.pop_front();
            if (kind !== e[8])
                report_mismatch($sformatf("kind got %0d want %0d", kind, e[8]));
            if (val !== e[7:0])
                report_mismatch($sformatf("value got %0d want %0d", val, e[7:0]));
        endtask

        task report_mismatch(string msg);
            $display("error: %s", msg);
            errors++;
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;   // opcode
    logic [7:0]  s_tdata = '0;   // pixel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        m_tuser;        // result_kind
    logic [7:0]  m_tdata;        // value
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    otsu_scoreboard sb = new();
    bit quiet = 1'b0;
    int n_items = 0;
    int n_frames = 0;
    int n_pixels = 0;

    always #2 aclk = ~aclk;

    otsu_threshold_binarizer i_dut (.*);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata);
            if (m_tuser == KIND_THRESH) n_frames++;
            else n_pixels++;
        end
    end

    // result side backpressure
    initial begin
        int k;
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                k = $urandom_range(1, 18);
                repeat (k) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                k = $urandom_range(1, 30);
                repeat (k) @(posedge aclk);
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] pix);
        if (!quiet && $urandom_range(0, 15) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, pix);
        n_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_level(logic [2:0] addr, logic [7:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == 3'd0) sb.lo = val;
        else sb.hi = val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_frame(int npix, int ncls);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 1) == 0)
                send_item(OP_ADD, 8'(c + $urandom_range(0, 40) - 20));
            else
                send_item(OP_ADD, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0) send_item(OP_NONE, 8'($urandom_range(0, 255)));
        send_item(OP_END, 8'($urandom_range(0, 255)));
        for (int i = 0; i < ncls; i++) send_item(OP_CLASSIFY, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_item(OP_END, 8'h00);
        send_item(OP_CLASSIFY, 8'h00);
        send_item(OP_CLASSIFY, 8'hff);
        send_item(OP_ADD, 8'h00);
        send_item(OP_ADD, 8'hff);
        send_item(OP_ADD, 8'hff);
        send_item(OP_NONE, 8'h55);
        send_item(OP_END, 8'haa);
        send_item(OP_CLASSIFY, 8'h7f);
        send_item(OP_CLASSIFY, 8'h80);
        send_item(OP_ADD, 8'h10);
        send_item(OP_END, 8'h00);
        drain();
        write_level(3'd0, 8'd200);
        write_level(3'd4, 8'd50);
        send_item(OP_ADD, 8'd10);
        send_item(OP_ADD, 8'd250);
        send_item(OP_END, 8'd0);
        send_item(OP_CLASSIFY, 8'd199);
        send_item(OP_CLASSIFY, 8'd200);
        drain();
        write_level(3'd0, 8'd40);
        write_level(3'd4, 8'd120);
        send_item(OP_ADD, 8'd0);
        send_item(OP_ADD, 8'd255);
        send_item(OP_ADD, 8'd80);
        drain();
        write_level(3'd4, 8'd255);
        send_item(OP_END, 8'd0);
        send_item(OP_CLASSIFY, 8'd3);
        drain();

        // random
        while (n_items < 1350) begin
            if ($urandom_range(0, 5) == 0) begin
                drain();
                case ($urandom_range(0, 4))
                    0: begin write_level(3'd0, 8'd0); write_level(3'd4, 8'd255); end
                    1: begin write_level(3'd0, 8'd255); write_level(3'd4, 8'd0); end
                    2: begin write_level(3'd0, 8'd100); write_level(3'd4, 8'd101); end
                    default: begin
                        write_level(3'd0, 8'($urandom_range(0, 255)));
                        write_level(3'd4, 8'($urandom_range(0, 255)));
                    end
                endcase
            end
            if (n_items > 1150) quiet = 1'b1;
            random_frame($urandom_range(0, 40), $urandom_range(1, 8));
        end
        drain();

        $display("covered %0d input transactions, %0d thresholds, %0d classified pixels",
                 n_items, n_frames, n_pixels);
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end
endmodule
